// File: rtl/ssp_pkg.sv
// Shared types and constants for the sorted source packet counter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned PROTO_W         = 8;

  // TCP protocol number, counted after reset
  localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  // One table entry as it travels between cells.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] cnt;
  } ssp_ent_t;

  // Per-cycle command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;     // compare stored address with the key
    logic bump;    // raise the hit entry with its incremented count
    logic append;  // store the key in the first free cell
    logic rotate;  // move the occupied entries one place toward the head
  } ssp_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/ssp_cell.sv
// One cell of the sorted table: holds one entry and trades it with its neighbors.
// Depends on ssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssp_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ssp_pkg::ssp_ctrl_t           ctrl_i,
  input  wire [ssp_pkg::ADDR_W-1:0]    key_i,
  input  wire [ssp_pkg::COUNT_W-1:0]   c_old_i,
  input  wire [ssp_pkg::COUNT_W-1:0]   c_new_i,
  input  ssp_pkg::ssp_ent_t            head_i,
  input  ssp_pkg::ssp_ent_t            prev_ent_i,
  input  wire                          prev_vld_i,
  input  wire                          prev_eq_i,
  input  ssp_pkg::ssp_ent_t            next_ent_i,
  input  wire                          next_vld_i,
  input  wire                          tail_i,
  input  wire [ssp_pkg::COUNT_W-1:0]   found_cnt_i,
  output ssp_pkg::ssp_ent_t            ent_o,
  output logic                         vld_o,
  output logic                         eq_o,
  output logic                         tail_o,
  output logic [ssp_pkg::COUNT_W-1:0]  found_cnt_o
);
  import ssp_pkg::*;

  ssp_ent_t ent_q, ent_d;
  logic     vld_q, vld_d;
  logic     hit_q;

  assign ent_o = ent_q;
  assign vld_o = vld_q;
  assign eq_o  = vld_q && (ent_q.cnt == c_old_i);
  // Cell sits at or before the hit position.
  assign tail_o = hit_q | tail_i;
  assign found_cnt_o = found_cnt_i | (hit_q ? ent_q.cnt : '0);

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    if (ctrl_i.bump && eq_o && tail_o) begin
      // Equal-count run up to the hit slides back one place; its front takes the key.
      if (prev_eq_i) begin
        ent_d = prev_ent_i;
      end else begin
        ent_d.addr = key_i;
        ent_d.cnt  = c_new_i;
      end
    end else if (ctrl_i.append && !vld_q && prev_vld_i) begin
      ent_d.addr = key_i;
      ent_d.cnt  = COUNT_W'(1);
      vld_d      = 1'b1;
    end else if (ctrl_i.rotate) begin
      if (next_vld_i) begin
        ent_d = next_ent_i;
      end else if (vld_q) begin
        ent_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (ctrl_i.cmp) begin
        hit_q <= vld_q && (ent_q.addr == key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

// File: rtl/sorted_source_packet_counter_top.sv
// Top level of the sorted source packet counter: sequencer plus a chain of ssp_cell.
// Depends on ssp_pkg and ssp_cell.
`timescale 1ns / 1ps
`default_nettype none

// Counts packets per IPv4 source for one protocol and keeps the sources sorted
// by descending count (ties keep their earlier order).
// Request channel: present protocol_number_i and source_address_i with start;
// the request is taken on a clock edge where start is high and busy is low.
// A request whose protocol differs from counted_protocol is taken and dropped
// in that same edge; busy never rises for it.
// A counted request runs compare, lookup and update, then lists the
// n occupied entries from the head of the chain, one per cycle, while the chain
// rotates. The first result follows the update step; busy stays high through
// all of these steps and drops after the last entry, n at most TABLE_DEPTH.
// Results: result_valid_o marks each listed entry for exactly one cycle;
// last_entry_o flags the final one; source_dropped_o flags every result of a
// packet whose new source found the table full. The receiver cannot stall.
// Configuration: cfg_we_i writes counted_protocol from cfg_wdata_i; write only
// while busy is low.
// Reset: table empty, counted_protocol = 6 (TCP), no clearing pass needed.
module sorted_source_packet_counter_top #(
  parameter int unsigned TABLE_DEPTH = ssp_pkg::TABLE_DEPTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ssp_pkg::PROTO_W-1:0]   cfg_wdata_i,
  input  wire                          start,
  output logic                         busy,
  input  wire [ssp_pkg::PROTO_W-1:0]   protocol_number_i,
  input  wire [ssp_pkg::ADDR_W-1:0]    source_address_i,
  output logic                         result_valid_o,
  output logic [ssp_pkg::ADDR_W-1:0]   entry_address_o,
  output logic [ssp_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         last_entry_o,
  output logic                         source_dropped_o
);
  import ssp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_LOOK,
    ST_UPD,
    ST_LIST
  } state_e;

  state_e                state_q;
  logic [PROTO_W-1:0]    proto_q;
  logic [ADDR_W-1:0]     key_q;
  logic [COUNT_W-1:0]    c_old_q;
  logic                  found_q;
  logic                  dropped_q;
  logic [OCC_W-1:0]      occ_q;
  logic [IDX_W-1:0]      idx_q;
  ssp_ctrl_t             ctrl;
  logic [COUNT_W-1:0]    c_new;

  ssp_ent_t              ent   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [TABLE_DEPTH-1:0] eq;
  logic [TABLE_DEPTH:0]  tail;
  logic [COUNT_W-1:0]    fcnt  [TABLE_DEPTH+1];

  logic                  is_last;
  logic                  full;

  assign full    = (occ_q == OCC_W'(TABLE_DEPTH));
  assign is_last = (OCC_W'(idx_q) == (occ_q - OCC_W'(1)));
  assign c_new   = c_old_q + COUNT_W'(1);

  always_comb begin
    ctrl        = '0;
    ctrl.cmp    = (state_q == ST_CMP);
    ctrl.bump   = (state_q == ST_UPD) && found_q && (c_old_q != COUNT_MAX);
    ctrl.append = (state_q == ST_UPD) && !found_q && !full;
    ctrl.rotate = (state_q == ST_LIST);
  end

  assign tail[TABLE_DEPTH] = 1'b0;
  assign fcnt[TABLE_DEPTH] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ssp_ent_t prev_ent;
    ssp_ent_t next_ent;
    logic     prev_vld;
    logic     prev_eq;
    logic     next_vld;

    if (i == 0) begin : g_first
      assign prev_ent = ent[0];
      assign prev_vld = 1'b1;
      assign prev_eq  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_vld = vld[i-1];
      assign prev_eq  = eq[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign next_ent = ent[i];
      assign next_vld = 1'b0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
      assign next_vld = vld[i+1];
    end

    ssp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key_q),
      .c_old_i     (c_old_q),
      .c_new_i     (c_new),
      .head_i      (ent[0]),
      .prev_ent_i  (prev_ent),
      .prev_vld_i  (prev_vld),
      .prev_eq_i   (prev_eq),
      .next_ent_i  (next_ent),
      .next_vld_i  (next_vld),
      .tail_i      (tail[i+1]),
      .found_cnt_i (fcnt[i+1]),
      .ent_o       (ent[i]),
      .vld_o       (vld[i]),
      .eq_o        (eq[i]),
      .tail_o      (tail[i]),
      .found_cnt_o (fcnt[i])
    );
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = (state_q == ST_LIST);
  assign entry_address_o  = ent[0].addr;
  assign entry_count_o    = ent[0].cnt;
  assign last_entry_o     = (state_q == ST_LIST) && is_last;
  assign source_dropped_o = (state_q == ST_LIST) && dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      proto_q   <= PROTO_RESET;
      occ_q     <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        proto_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start && (protocol_number_i == proto_q)) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          found_q   <= tail[0];
          dropped_q <= !tail[0] && full;
          state_q   <= ST_UPD;
        end
        ST_UPD: begin
          if (ctrl.append) begin
            occ_q <= occ_q + OCC_W'(1);
          end
          idx_q   <= '0;
          state_q <= ST_LIST;
        end
        ST_LIST: begin
          idx_q <= idx_q + IDX_W'(1);
          if (is_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Key and looked-up count carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      key_q <= source_address_i;
    end
    if (state_q == ST_LOOK) begin
      c_old_q <= fcnt[0];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TABLE_DEPTH))
    else $error("occupied count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(occ_q))
    else $error("cell valid bits disagree with occupied count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> entry_count_o != '0)
    else $error("listed entry has zero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |=> result_valid_o)
    else $error("listing ended before the last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    source_dropped_o |-> full)
    else $error("source dropped while table had room");

endmodule

`default_nettype wire
